[hdl/cfr_pkg.sv]
`default_nettype none

package cfr_pkg;

	localparam int FRAMES_DEF = 64;
	localparam int OWNER_BITS_DEF = 8;

	localparam int OP_W = 3;
	localparam int OWNER_W = 8;
	localparam int SLOT_FIELD_W = 6;
	localparam int STATUS_W = 2;
	localparam int POOL_CFG_W = 7;

	localparam logic [POOL_CFG_W-1:0] POOL_RESET = 7'd64;

	localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
	localparam logic [OP_W-1:0] OP_DESTROY = 3'd2;
	localparam logic [OP_W-1:0] OP_REF     = 3'd3;
	localparam logic [OP_W-1:0] OP_MARK    = 3'd4;

	localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EVICT    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NO_FRAME = 2'd2;
	localparam logic [STATUS_W-1:0] STS_NO_MATCH = 2'd3;

	// Controller states; the datapath receives the same code as its mode.
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIND    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SWEEP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SINGLE  = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]         operation;
		logic [OWNER_W-1:0]      owner;
		logic [SLOT_FIELD_W-1:0] frame_slot;
		logic                    write_access;
	} cfr_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [SLOT_FIELD_W-1:0] granted_slot;
		logic [OWNER_W-1:0]      victim_owner;
		logic                    victim_dirty;
	} cfr_out_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              accept;
		logic              step;
		logic              restart;
	} cfr_cmd_t;

	typedef struct packed {
		logic done;
		logic find_miss;
		logic clear_end;
		logic out_busy;
	} cfr_stat_t;

endpackage

`default_nettype wire

[hdl/cfr_ctrl.sv]
`default_nettype none

module cfr_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [cfr_pkg::OP_W-1:0] in_operation,
	output logic                     in_stall,
	output cfr_pkg::cfr_cmd_t        cmd,
	input  cfr_pkg::cfr_stat_t       stat
);
	import cfr_pkg::*;

	logic [MODE_W-1:0] state_q;
	logic [MODE_W-1:0] state_d;

	always_comb begin
		cmd = '0;
		cmd.mode = state_q;
		state_d = state_q;
		case (state_q)
			MODE_CLEAR: begin
				cmd.step = 1'b1;
				if (stat.clear_end) begin
					state_d = MODE_IDLE;
				end
			end
			MODE_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (in_operation)
						OP_ALLOC:   state_d = MODE_FIND;
						OP_DESTROY: state_d = MODE_DESTROY;
						default:    state_d = MODE_SINGLE;
					endcase
				end
			end
			MODE_FIND, MODE_SWEEP, MODE_DESTROY, MODE_SINGLE: begin
				// A finished transaction waits here while the output register is still full.
				cmd.step = !(stat.done && stat.out_busy);
				if (state_q == MODE_FIND && stat.find_miss) begin
					cmd.restart = 1'b1;
					state_d = MODE_SWEEP;
				end else if (stat.done && !stat.out_busy) begin
					state_d = MODE_IDLE;
				end
			end
			default: state_d = MODE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MODE_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != MODE_IDLE);

endmodule

`default_nettype wire

[hdl/cfr_datapath.sv]
`default_nettype none

module cfr_datapath #(
	parameter int FRAMES     = cfr_pkg::FRAMES_DEF,
	parameter int OWNER_BITS = cfr_pkg::OWNER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfr_pkg::cfr_cmd_t              cmd,
	output cfr_pkg::cfr_stat_t             stat,
	input  cfr_pkg::cfr_in_t               in_data,
	input  logic                           cfg_wr_en,
	input  logic [cfr_pkg::POOL_CFG_W-1:0] cfg_wr_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cfr_pkg::cfr_out_t              out_data
);
	import cfr_pkg::*;

	localparam int SLOT_W = $clog2(FRAMES);
	localparam int POOL_W = $clog2(FRAMES + 1);
	localparam int CMP_W = (POOL_W > POOL_CFG_W) ? POOL_W : POOL_CFG_W;
	localparam int SCMP_W = (POOL_W > SLOT_FIELD_W) ? POOL_W : SLOT_FIELD_W;
	localparam int CNT_W = $clog2(2 * FRAMES);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FRAMES - 1);

	typedef struct packed {
		logic in_use;
		logic loaded;
		logic accessed;
		logic dirty;
	} cfr_flags_t;

	cfr_flags_t flag_mem [FRAMES];
	logic [OWNER_BITS-1:0] owner_mem [FRAMES];

	logic [POOL_CFG_W-1:0] pool_cfg_q;
	cfr_in_t               item_q;
	logic [SLOT_W-1:0]     rp_q;
	logic                  ev_q;
	logic [SLOT_W-1:0]     ev_slot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SLOT_W-1:0]     hand_q;
	cfr_flags_t            rd_flags_q;
	logic [OWNER_BITS-1:0] rd_owner_q;
	logic                  out_valid_q;
	cfr_out_t              out_q;

	logic [CMP_W-1:0]      cfg_ext;
	logic [POOL_W-1:0]     pool;
	logic [SLOT_W-1:0]     last;
	logic [SLOT_W-1:0]     h0;
	logic [SLOT_W-1:0]     wrap_last;
	logic [SLOT_W-1:0]     rp_next;
	logic [SLOT_W-1:0]     hand_next;
	logic [SLOT_W-1:0]     start_slot;
	logic [CNT_W-1:0]      cnt_last;
	logic [OWNER_BITS-1:0] who;
	logic                  in_slot_ok;
	logic                  slot_ok;
	logic                  owner_hit;
	logic                  cand;
	logic                  re;
	logic                  wr_en;
	logic                  own_en;
	logic                  we;
	logic                  own_we;
	logic [SLOT_W-1:0]     wr_addr;
	cfr_flags_t            wr_flags;
	logic                  done;
	logic                  find_miss;
	logic                  hand_load;
	cfr_out_t              res;

	// Effective pool size, clamped to one through FRAMES.
	always_comb begin
		cfg_ext = CMP_W'(pool_cfg_q);
		if (cfg_ext == '0) begin
			pool = POOL_W'(1);
		end else if (cfg_ext > CMP_W'(FRAMES)) begin
			pool = POOL_W'(FRAMES);
		end else begin
			pool = POOL_W'(cfg_ext);
		end
	end

	assign last = SLOT_W'(pool - POOL_W'(1));
	assign h0 = (hand_q > last) ? '0 : hand_q;
	assign cnt_last = CNT_W'({pool, 1'b0} - 1'b1);
	assign wrap_last = (cmd.mode == MODE_FIND || cmd.mode == MODE_SWEEP) ? last : SLOT_LAST;
	assign rp_next = (rp_q == wrap_last) ? '0 : rp_q + SLOT_W'(1);
	assign hand_next = (ev_slot_q == last) ? '0 : ev_slot_q + SLOT_W'(1);

	assign in_slot_ok = SCMP_W'(in_data.frame_slot) < SCMP_W'(FRAMES);
	assign slot_ok = SCMP_W'(item_q.frame_slot) < SCMP_W'(FRAMES);
	assign start_slot = (in_data.operation == OP_ALLOC || in_data.operation == OP_DESTROY ||
		!in_slot_ok) ? '0 : SLOT_W'(in_data.frame_slot);

	assign who = OWNER_BITS'(item_q.owner);
	assign owner_hit = (rd_owner_q == who);
	assign cand = rd_flags_q.in_use && rd_flags_q.loaded;
	assign re = cmd.step && (cmd.mode inside {MODE_FIND, MODE_SWEEP, MODE_DESTROY, MODE_SINGLE});

	always_comb begin
		wr_en = 1'b0;
		own_en = 1'b0;
		wr_flags = '0;
		done = 1'b0;
		find_miss = 1'b0;
		hand_load = 1'b0;
		res = '0;
		res.status = STS_DONE;
		case (cmd.mode)
			MODE_CLEAR: begin
				wr_en = 1'b1;
			end
			MODE_FIND: begin
				if (ev_q) begin
					if (!rd_flags_q.in_use) begin
						wr_en = 1'b1;
						own_en = 1'b1;
						wr_flags.in_use = 1'b1;
						done = 1'b1;
						res.granted_slot = SLOT_FIELD_W'(ev_slot_q);
					end else if (ev_slot_q == last) begin
						find_miss = 1'b1;
					end
				end
			end
			MODE_SWEEP: begin
				if (ev_q) begin
					if (cand && !rd_flags_q.accessed) begin
						wr_en = 1'b1;
						own_en = 1'b1;
						wr_flags.in_use = 1'b1;
						done = 1'b1;
						hand_load = 1'b1;
						res.status = STS_EVICT;
						res.granted_slot = SLOT_FIELD_W'(ev_slot_q);
						res.victim_owner = OWNER_W'(rd_owner_q);
						res.victim_dirty = rd_flags_q.dirty;
					end else begin
						if (cand) begin
							wr_en = 1'b1;
							wr_flags = rd_flags_q;
							wr_flags.accessed = 1'b0;
						end
						// After two full rounds the hand is back where it started.
						if (cnt_q == cnt_last) begin
							done = 1'b1;
							hand_load = 1'b1;
							res.status = STS_NO_FRAME;
						end
					end
				end
			end
			MODE_DESTROY: begin
				if (ev_q) begin
					wr_en = rd_flags_q.in_use && owner_hit;
					done = (ev_slot_q == SLOT_LAST);
				end
			end
			MODE_SINGLE: begin
				if (ev_q) begin
					done = 1'b1;
					wr_flags = rd_flags_q;
					case (item_q.operation)
						OP_FREE: begin
							if (slot_ok && rd_flags_q.in_use && owner_hit) begin
								wr_en = 1'b1;
								wr_flags = '0;
							end else begin
								res.status = STS_NO_MATCH;
							end
						end
						OP_REF: begin
							wr_en = slot_ok && rd_flags_q.in_use;
							wr_flags.accessed = 1'b1;
							wr_flags.dirty = rd_flags_q.dirty || item_q.write_access;
						end
						OP_MARK: begin
							wr_en = slot_ok && rd_flags_q.in_use;
							wr_flags.loaded = 1'b1;
						end
						default: wr_en = 1'b0;
					endcase
				end
			end
			default: done = 1'b0;
		endcase
	end

	assign wr_addr = (cmd.mode == MODE_CLEAR) ? rp_q : ev_slot_q;
	assign we = wr_en && cmd.step;
	assign own_we = own_en && cmd.step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cfg_q <= POOL_RESET;
			rp_q <= '0;
			ev_q <= 1'b0;
			cnt_q <= '0;
			hand_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pool_cfg_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				rp_q <= start_slot;
				ev_q <= 1'b0;
				cnt_q <= '0;
			end else if (cmd.restart) begin
				rp_q <= h0;
				ev_q <= 1'b0;
				cnt_q <= '0;
			end else if (cmd.step) begin
				rp_q <= rp_next;
				ev_q <= re;
				if (ev_q && cmd.mode == MODE_SWEEP) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.step && hand_load) begin
				hand_q <= hand_next;
			end
			if (cmd.step && done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_data;
		end
		if (re) begin
			ev_slot_q <= rp_q;
		end
		if (cmd.step && done) begin
			out_q <= res;
		end
	end

	// Frame table; a read of the entry being written returns the new contents.
	always_ff @(posedge clk) begin
		if (we) begin
			flag_mem[wr_addr] <= wr_flags;
		end
		if (re) begin
			rd_flags_q <= (we && wr_addr == rp_q) ? wr_flags : flag_mem[rp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (own_we) begin
			owner_mem[wr_addr] <= who;
		end
		if (re) begin
			rd_owner_q <= (own_we && wr_addr == rp_q) ? who : owner_mem[rp_q];
		end
	end

	assign stat.done = done;
	assign stat.find_miss = find_miss;
	assign stat.clear_end = (rp_q == SLOT_LAST);
	assign stat.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

[hdl/clock_frame_replacement_core.sv]
`default_nettype none

// Frame table with second-chance clock replacement. One transaction is worked on at a time;
// the frame table sits in a single-port-read memory, so slots are visited one at a time.
// After reset the block clears every slot of the table with in_stall high. Free, reference,
// mark loaded and unknown operations visit one slot; destroy visits every slot. Allocate
// scans the pool from slot 0 up to the lowest free slot; when the pool is full it scans the
// whole pool and then runs a clock sweep of up to two full rounds of the pool, ending early
// at the first loaded slot whose accessed bit is clear. A finished result sits in an output
// register, so the next transaction can be accepted and worked on while it waits; a
// transaction that finishes while that register is still full holds until it empties.
module clock_frame_replacement_core #(
	parameter int FRAMES     = cfr_pkg::FRAMES_DEF,
	parameter int OWNER_BITS = cfr_pkg::OWNER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cfr_pkg::cfr_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cfr_pkg::cfr_out_t              out_data,
	input  logic                           cfg_wr_en,
	input  logic [cfr_pkg::POOL_CFG_W-1:0] cfg_wr_data
);
	import cfr_pkg::*;

	cfr_cmd_t  cmd;
	cfr_stat_t stat;

	cfr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_operation (in_data.operation),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	cfr_datapath #(
		.FRAMES     (FRAMES),
		.OWNER_BITS (OWNER_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

[hdl/cfr_checker.sv]
`default_nettype none

module cfr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input cfr_pkg::cfr_out_t out_data
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed while stalled");

	// Each transaction is worked on alone, so intake closes right after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while one is in work");

	// A new result appears only as the block returns to idle.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result appeared while the block is still busy");

endmodule

bind clock_frame_replacement_core cfr_checker u_cfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

[bench/clock_frame_replacement_core_test.sv]
`default_nettype none

module clock_frame_replacement_core_test;
	import cfr_pkg::*;

	localparam int SLOTS = FRAMES_DEF;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASES = 8;
	localparam int PHASE_EVENTS = 210;

	// Frame table predictor and store of expected replies.
	class frame_table_scoreboard;
		bit in_use[SLOTS];
		bit loaded[SLOTS];
		bit accessed[SLOTS];
		bit dirty[SLOTS];
		bit [OWNER_W-1:0] owner_of[SLOTS];
		int unsigned hand;
		logic [POOL_CFG_W-1:0] pool_reg;
		cfr_out_t expected_replies[$];
		int failures;

		function new();
			int i;
			for (i = 0; i < SLOTS; i++) begin
				in_use[i] = 0;
				loaded[i] = 0;
				accessed[i] = 0;
				dirty[i] = 0;
				owner_of[i] = '0;
			end
			hand = 0;
			pool_reg = POOL_RESET;
			failures = 0;
		endfunction

		function void set_pool(logic [POOL_CFG_W-1:0] v);
			pool_reg = v;
		endfunction

		function int unsigned active_pool();
			if (pool_reg == 0)
				return 1;
			if (pool_reg > SLOTS)
				return SLOTS;
			return pool_reg;
		endfunction

		function void claim(int unsigned s, bit [OWNER_W-1:0] who);
			in_use[s] = 1;
			loaded[s] = 0;
			accessed[s] = 0;
			dirty[s] = 0;
			owner_of[s] = who;
		endfunction

		function void release_slot(int unsigned s);
			in_use[s] = 0;
			loaded[s] = 0;
			accessed[s] = 0;
			dirty[s] = 0;
		endfunction

		function cfr_out_t apply_event(cfr_in_t ev);
			cfr_out_t r;
			int unsigned pool, h, s, i, steps;
			bit found;
			r = '0;
			pool = active_pool();
			s = ev.frame_slot;
			found = 0;
			case (ev.operation)
				OP_ALLOC: begin
					for (i = 0; i < pool && !found; i++) begin
						if (!in_use[i]) begin
							claim(i, ev.owner);
							r.granted_slot = SLOT_FIELD_W'(i);
							found = 1;
						end
					end
					if (!found) begin
						h = (hand >= pool) ? 0 : hand;
						r.status = STS_NO_FRAME;
						// Second chance: at most two full rounds of the pool.
						for (steps = 0; steps < 2 * pool && !found; steps++) begin
							if (in_use[h] && loaded[h]) begin
								if (accessed[h]) begin
									accessed[h] = 0;
								end else begin
									r.victim_owner = owner_of[h];
									r.victim_dirty = dirty[h];
									claim(h, ev.owner);
									r.granted_slot = SLOT_FIELD_W'(h);
									r.status = STS_EVICT;
									found = 1;
								end
							end
							h = (h + 1 >= pool) ? 0 : h + 1;
						end
						hand = h;
					end
				end
				OP_FREE: begin
					if (s < SLOTS && in_use[s] && owner_of[s] == ev.owner)
						release_slot(s);
					else
						r.status = STS_NO_MATCH;
				end
				OP_DESTROY: begin
					for (i = 0; i < SLOTS; i++)
						if (in_use[i] && owner_of[i] == ev.owner)
							release_slot(i);
				end
				OP_REF: begin
					if (s < SLOTS && in_use[s]) begin
						accessed[s] = 1;
						if (ev.write_access)
							dirty[s] = 1;
					end
				end
				OP_MARK: begin
					if (s < SLOTS && in_use[s])
						loaded[s] = 1;
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_request(cfr_in_t ev);
			expected_replies.push_back(apply_event(ev));
		endfunction

		function void check_reply(cfr_out_t got);
			cfr_out_t want;
			if (expected_replies.size() == 0) begin
				$error("unexpected result %h with nothing outstanding", got);
				failures++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.granted_slot !== want.granted_slot) begin
				$error("granted_slot: expected %0d, actual %0d",
					want.granted_slot, got.granted_slot);
				failures++;
			end
			if (got.victim_owner !== want.victim_owner) begin
				$error("victim_owner: expected %0d, actual %0d",
					want.victim_owner, got.victim_owner);
				failures++;
			end
			if (got.victim_dirty !== want.victim_dirty) begin
				$error("victim_dirty: expected %0d, actual %0d",
					want.victim_dirty, got.victim_dirty);
				failures++;
			end
		endfunction

		function int outstanding();
			return expected_replies.size();
		endfunction

		// Returns a slot that is currently in use, or -1 when the table is empty.
		function int pick_busy_slot();
			int busy[$];
			int i;
			for (i = 0; i < SLOTS; i++)
				if (in_use[i])
					busy.push_back(i);
			if (busy.size() == 0)
				return -1;
			return busy[$urandom_range(0, busy.size() - 1)];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	cfr_in_t in_data;
	logic out_valid;
	logic out_stall;
	cfr_out_t out_data;
	logic cfg_wr_en;
	logic [POOL_CFG_W-1:0] cfg_wr_data;

	frame_table_scoreboard sb = new();
	bit idling_on;
	int cycle_count;

	clock_frame_replacement_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idling_on = 1'b1;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_reply(out_data);
	end

	// The result side holds off in bursts while idling is enabled.
	always begin : result_stall
		int n;
		@(posedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 11);
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	function automatic cfr_in_t make_event(logic [OP_W-1:0] op, int unsigned who,
			int unsigned slot, bit wr);
		cfr_in_t ev;
		ev.operation = op;
		ev.owner = OWNER_W'(who);
		ev.frame_slot = SLOT_FIELD_W'(slot);
		ev.write_access = wr;
		return ev;
	endfunction

	function automatic cfr_in_t random_event();
		cfr_in_t ev;
		int unsigned pick, pool;
		int busy;
		pool = sb.active_pool();
		pick = $urandom_range(0, 99);
		ev.write_access = 1'($urandom_range(0, 1));
		ev.owner = OWNER_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, (1 << OWNER_W) - 1)
			: $urandom_range(0, 3));
		ev.frame_slot = SLOT_FIELD_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, SLOTS - 1)
			: $urandom_range(0, pool - 1));
		if (pick < 30) begin
			ev.operation = OP_ALLOC;
		end else if (pick < 40) begin
			ev.operation = OP_FREE;
			// Mostly free a slot that the right owner really holds.
			busy = sb.pick_busy_slot();
			if (busy >= 0 && $urandom_range(0, 9) < 7) begin
				ev.frame_slot = SLOT_FIELD_W'(busy);
				ev.owner = sb.owner_of[busy];
			end
		end else if (pick < 43) begin
			ev.operation = OP_DESTROY;
		end else if (pick < 70) begin
			ev.operation = OP_REF;
		end else if (pick < 95) begin
			ev.operation = OP_MARK;
		end else begin
			ev.operation = OP_W'($urandom_range(int'(OP_MARK) + 1, (1 << OP_W) - 1));
		end
		return ev;
	endfunction

	task automatic send_event(input cfr_in_t ev);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= ev;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.note_request(ev);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pool(input logic [POOL_CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.set_pool(v);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		cfr_in_t directed[$];
		logic [POOL_CFG_W-1:0] phase_pool[PHASES];
		int p, k;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);

		// Two-frame pool: fill it, fail to find a victim, then evict both ways.
		write_pool(POOL_CFG_W'(2));
		directed.push_back(make_event(OP_ALLOC, 0, 0, 0));
		directed.push_back(make_event(OP_ALLOC, 255, 63, 1));
		directed.push_back(make_event(OP_ALLOC, 7, 0, 0));
		directed.push_back(make_event(OP_MARK, 0, 0, 0));
		directed.push_back(make_event(OP_MARK, 0, 1, 0));
		directed.push_back(make_event(OP_REF, 0, 0, 1));
		directed.push_back(make_event(OP_REF, 0, 63, 1));
		directed.push_back(make_event(OP_ALLOC, 9, 0, 0));
		directed.push_back(make_event(OP_ALLOC, 10, 0, 0));
		directed.push_back(make_event(OP_FREE, 9, 0, 0));
		directed.push_back(make_event(OP_FREE, 10, 0, 0));
		directed.push_back(make_event(OP_FREE, 10, 0, 0));
		directed.push_back(make_event(OP_FREE, 0, 63, 0));
		directed.push_back(make_event(OP_DESTROY, 9, 0, 0));
		directed.push_back(make_event(OP_DESTROY, 200, 63, 1));
		directed.push_back(make_event(OP_W'(int'(OP_MARK) + 1), 255, 63, 1));
		directed.push_back(make_event(OP_W'(int'(OP_MARK) + 2), 255, 63, 1));
		directed.push_back(make_event(OP_W'(int'(OP_MARK) + 3), 255, 63, 1));
		directed.push_back(make_event(OP_MARK, 0, 2, 0));
		directed.push_back(make_event(OP_REF, 0, 0, 0));
		foreach (directed[i])
			send_event(directed[i]);
		drain_results();

		phase_pool[0] = 7'd127;
		phase_pool[1] = 7'd0;
		phase_pool[2] = 7'd1;
		phase_pool[3] = 7'd6;
		phase_pool[4] = 7'd64;
		phase_pool[5] = POOL_CFG_W'($urandom_range(2, 12));
		phase_pool[6] = 7'd3;
		phase_pool[7] = POOL_CFG_W'($urandom_range(1, 16));

		for (p = 0; p < PHASES; p++) begin
			write_pool(phase_pool[p]);
			for (k = 0; k < PHASE_EVENTS; k++) begin
				if (p == PHASES - 1)
					idling_on = 1'b0;
				else if (k % 50 == 0)
					idling_on = ($urandom_range(0, 3) != 0);
				// Let everything outstanding come back once in mid-phase.
				if (p == 3 && k == PHASE_EVENTS / 2)
					drain_results();
				send_event(random_event());
			end
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
